// File: design/vpcv_pkg.sv
// Shared types and constants of the vertex projection engine.
`default_nettype none
package vpcv_pkg;

  localparam int CoordW   = 32;
  localparam int FracBits = 16;
  localparam int ScrFrac  = 4;
  localparam int CfgW     = 13;
  localparam int CfgIdxW  = 2;
  localparam int MatIdxW  = 5;

  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_POINT = 1'b1;

  localparam logic [CfgIdxW-1:0] CFG_SCREEN_WIDTH  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_SCREEN_HEIGHT = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_FALLBACK_X    = 2'd2;

  typedef struct packed {
    logic                     mode;
    logic [MatIdxW-1:0]       idx;
    logic signed [CoordW-1:0] val;
    logic signed [CoordW-1:0] px;
    logic signed [CoordW-1:0] py;
    logic signed [CoordW-1:0] pz;
  } item_t;

endpackage
`default_nettype wire

// File: design/vpcv_front.sv
// Input stage: accepts beats into a two-entry queue ahead of the engine.
`default_nettype none
module vpcv_front (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic               mode_i,
  input  wire logic [4:0]         matrix_index_i,
  input  wire logic signed [31:0] matrix_value_i,
  input  wire logic signed [31:0] point_x_i,
  input  wire logic signed [31:0] point_y_i,
  input  wire logic signed [31:0] point_z_i,
  output vpcv_pkg::item_t         q_item_o,
  output logic                    q_valid_o,
  input  wire logic               q_pop_i
);
  import vpcv_pkg::*;

  item_t      mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign in_stall_o = (cnt_q == 2'd2);
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_item_o   = mem_q[rd_ptr_q];
  assign push       = in_valid_i && !in_stall_o;
  assign pop        = q_pop_i && q_valid_o;

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= '{mode: mode_i, idx: matrix_index_i, val: matrix_value_i,
                          px: point_x_i, py: point_y_i, pz: point_z_i};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= !wr_ptr_q;
      if (pop)  rd_ptr_q <= !rd_ptr_q;
      case ({push, pop})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: design/vpcv_back.sv
// Engine: matrix loads, two matrix-vector passes, clip test, viewport divide.
`default_nettype none
module vpcv_back (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  vpcv_pkg::item_t          q_item_i,
  input  wire logic                q_valid_i,
  output logic                     q_pop_o,
  input  wire logic [12:0]         screen_width_i,
  input  wire logic [12:0]         screen_height_i,
  input  wire logic [12:0]         fallback_x_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic                     visible_o,
  output logic [15:0]              screen_x_o,
  output logic [15:0]              screen_y_o
);
  import vpcv_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MAC  = 3'd1;
  localparam logic [2:0] S_PREP = 3'd2;
  localparam logic [2:0] S_DIV0 = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  localparam logic [5:0] StepBubble = 6'd16;
  localparam logic [5:0] StepLast   = 6'd33;
  localparam logic [5:0] DivLast    = 6'd16;

  function automatic logic signed [31:0] round_sat(input logic signed [65:0] a);
    logic signed [65:0] t;
    logic signed [49:0] s;
    t = a + 66'sd32768;
    s = t[65:16];
    if (s > 50'sd2147483647)       round_sat = 32'sh7fffffff;
    else if (s < -50'sd2147483648) round_sat = 32'sh80000000;
    else                           round_sat = s[31:0];
  endfunction

  function automatic logic [15:0] sat16(input logic [16:0] v);
    sat16 = v[16] ? 16'hffff : v[15:0];
  endfunction

  logic [2:0]  state_q;
  logic [5:0]  step_q;
  logic signed [31:0] mat_q [32];
  logic signed [31:0] pt_q  [3];
  logic signed [31:0] v_q   [4];
  logic signed [31:0] c_q   [4];
  logic signed [63:0] prod_q;
  logic        pvld_q, pfirst_q, plast_q, psel_q;
  logic [1:0]  prow_q;
  logic signed [65:0] acc_q;
  logic        vis_q;
  logic [49:0] mx_q, my_q, dsh_q;
  logic [32:0] den_q;
  logic [51:0] remx_q, remy_q;
  logic [16:0] qx_q, qy_q;
  logic        out_valid_q, vis_out_q;
  logic [15:0] sx_q, sy_q;

  // multiply operand selection
  logic        issue, sel;
  logic [5:0]  kk;
  logic [3:0]  k;
  logic [1:0]  row, col;
  logic signed [31:0] op_a, op_b;
  logic signed [65:0] acc_sum;

  assign issue = (state_q == S_MAC) && (step_q != StepBubble) && (step_q != StepLast);
  assign sel   = (step_q > StepBubble);
  assign kk    = sel ? (step_q - 6'd17) : step_q;
  assign k     = kk[3:0];
  assign row   = k[3:2];
  assign col   = k[1:0];
  assign op_a  = mat_q[{sel, col, row}];
  always_comb begin
    if (sel)          op_b = v_q[col];
    else if (col == 2'd3) op_b = 32'sd65536;
    else              op_b = pt_q[col];
  end
  assign acc_sum = (pfirst_q ? 66'sd0 : acc_q) + 66'(prod_q);

  // clip test and numerators
  logic signed [33:0] xs, ys, zs, ws, nws, numx, numy;
  logic        in_box;
  logic [16:0] scale_w, scale_h, fbx, fby;
  assign xs   = 34'(c_q[0]);
  assign ys   = 34'(c_q[1]);
  assign zs   = 34'(c_q[2]);
  assign ws   = 34'(c_q[3]);
  assign nws  = -ws;
  assign numx = xs + ws;
  assign numy = ws - ys;
  assign in_box = (ws != 34'sd0) && (xs <= ws) && (xs >= nws) && (ys <= ws) &&
                  (ys >= nws) && (zs <= ws) && (zs >= nws);
  assign scale_w = {screen_width_i, 4'b0};
  assign scale_h = {screen_height_i, 4'b0};
  assign fbx     = {fallback_x_i, 4'b0};
  assign fby     = {screen_height_i, 4'b0};

  logic        gex, gey;
  assign gex = (remx_q >= {2'b0, dsh_q});
  assign gey = (remy_q >= {2'b0, dsh_q});

  logic out_free;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign q_pop_o     = (state_q == S_IDLE) && q_valid_i;
  assign out_valid_o = out_valid_q;
  assign visible_o   = vis_out_q;
  assign screen_x_o  = sx_q;
  assign screen_y_o  = sy_q;

  // datapath
  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      if (q_item_i.mode == MODE_LOAD) begin
        mat_q[q_item_i.idx] <= q_item_i.val;
      end else begin
        pt_q[0] <= q_item_i.px;
        pt_q[1] <= q_item_i.py;
        pt_q[2] <= q_item_i.pz;
      end
    end
    prod_q   <= op_a * op_b;
    pfirst_q <= (col == 2'd0);
    plast_q  <= (col == 2'd3);
    prow_q   <= row;
    psel_q   <= sel;
    if (pvld_q) begin
      acc_q <= acc_sum;
      if (plast_q) begin
        if (psel_q) c_q[prow_q] <= round_sat(acc_sum);
        else        v_q[prow_q] <= round_sat(acc_sum);
      end
    end
    if (state_q == S_PREP) begin
      vis_q <= in_box;
      mx_q  <= scale_w * numx[32:0];
      my_q  <= scale_h * numy[32:0];
      den_q <= ws[32:0] + ws[32:0];
    end
    if (state_q == S_DIV0) begin
      remx_q <= {1'b0, mx_q, 1'b0} + 52'(den_q);
      remy_q <= {1'b0, my_q, 1'b0} + 52'(den_q);
      dsh_q  <= {den_q, 17'b0};
    end
    if (state_q == S_DIV) begin
      if (gex) remx_q <= remx_q - {2'b0, dsh_q};
      if (gey) remy_q <= remy_q - {2'b0, dsh_q};
      qx_q  <= {qx_q[15:0], gex};
      qy_q  <= {qy_q[15:0], gey};
      dsh_q <= dsh_q >> 1;
    end
    if (state_q == S_OUT && out_free) begin
      vis_out_q <= vis_q;
      sx_q      <= vis_q ? sat16(qx_q) : sat16(fbx);
      sy_q      <= vis_q ? sat16(qy_q) : sat16(fby);
    end
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= 6'd0;
      pvld_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      pvld_q      <= issue;
      out_valid_q <= (state_q == S_OUT && out_free) || (out_valid_q && out_stall_i);
      case (state_q)
        S_IDLE: begin
          if (q_pop_o && q_item_i.mode == MODE_POINT) begin
            step_q  <= 6'd0;
            state_q <= S_MAC;
          end
        end
        S_MAC: begin
          step_q <= step_q + 6'd1;
          if (step_q == StepLast) state_q <= S_PREP;
        end
        S_PREP: begin
          state_q <= in_box ? S_DIV0 : S_OUT;
        end
        S_DIV0: begin
          step_q  <= 6'd0;
          state_q <= S_DIV;
        end
        S_DIV: begin
          step_q <= step_q + 6'd1;
          if (step_q == DivLast) state_q <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: design/vertex_project_clip_viewport.sv
// Top level of the vertex projection engine: configuration, input queue, engine.
//
// Input channel (in_valid_i / in_stall_o): a beat with mode_i = 0 writes one Q16.16
// matrix entry (index 0-15 view, 16-31 projection, column-major) and gives no
// result. A beat with mode_i = 1 transforms a world point and gives one result.
// All 32 entries must be loaded before the first point.
// Output channel (out_valid_o / out_stall_i): visible_o, screen_x_o, screen_y_o in
// Q12.4 pixels, y from the top; clipped points return the fallback point.
// Steps: a load writes its entry when the engine takes it from the queue. A point
// passes through one shared 32x32 multiply-accumulate for both matrix passes, a
// prep step, the two parallel bit-serial dividers and an output step; a clipped
// point skips the dividers.
// A two-beat queue in front takes beats while the engine works, until it is full,
// and the output register holds a result while the next point is computed.
// Reset clears control state and sets width 1024, height 768, fallback x 512;
// matrices are undefined until loaded. When the receiver stalls, the result is
// held and the engine waits at its output step until the register frees.
// Configuration writes (cfg_we_i) take effect at once; the user must make them while idle (not enforced).
`default_nettype none
module vertex_project_clip_viewport (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [1:0]         cfg_index_i,
  input  wire logic [12:0]        cfg_data_i,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic               mode_i,
  input  wire logic [4:0]         matrix_index_i,
  input  wire logic signed [31:0] matrix_value_i,
  input  wire logic signed [31:0] point_x_i,
  input  wire logic signed [31:0] point_y_i,
  input  wire logic signed [31:0] point_z_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic                    visible_o,
  output logic [15:0]             screen_x_o,
  output logic [15:0]             screen_y_o
);
  import vpcv_pkg::*;

  logic [12:0] width_q, height_q, fbx_q;
  item_t       q_item;
  logic        q_valid, q_pop;

  // Hold configuration; unknown indexes drop.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 13'd1024;
      height_q <= 13'd768;
      fbx_q    <= 13'd512;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_SCREEN_WIDTH:  width_q  <= cfg_data_i;
        CFG_SCREEN_HEIGHT: height_q <= cfg_data_i;
        CFG_FALLBACK_X:    fbx_q    <= cfg_data_i;
        default:           ;
      endcase
    end
  end

  vpcv_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .mode_i, .matrix_index_i,
    .matrix_value_i, .point_x_i, .point_y_i, .point_z_i,
    .q_item_o(q_item), .q_valid_o(q_valid), .q_pop_i(q_pop)
  );

  vpcv_back u_back (
    .clk_i, .rst_ni, .q_item_i(q_item), .q_valid_i(q_valid), .q_pop_o(q_pop),
    .screen_width_i(width_q), .screen_height_i(height_q), .fallback_x_i(fbx_q),
    .out_valid_o, .out_stall_i, .visible_o, .screen_x_o, .screen_y_o
  );

endmodule
`default_nettype wire
